/* rtl/sbi_pkg.sv */
`timescale 1ns / 1ps
package sbi_pkg;
    localparam int SBI_COORD_WIDTH = 24;

    typedef struct packed {
        logic en;
        logic vld;
    } t_stage_ctl;
endpackage

/* rtl/sbi_if.sv */
`timescale 1ns / 1ps
interface sbi_in_if #(
    parameter int COORD_WIDTH = sbi_pkg::SBI_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_z;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z,
        output ready
    );
endinterface

interface sbi_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

/* rtl/segment_box_intersect.sv */
`timescale 1ns / 1ps
// Throughput: one request per cycle; the eight stages advance together and hold
// while a result waits on o_out.ready.
// Reset: synchronous, active low; clears all stage valid bits and the output valid.
module segment_box_intersect #(
    parameter int COORD_WIDTH = sbi_pkg::SBI_COORD_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbi_in_if.sink    i_in,
    sbi_out_if.source o_out
);
    import sbi_pkg::*;

    localparam int NW = COORD_WIDTH + 2;
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = NW + DW + 1;

    logic en;

    logic signed [NW-1:0] a_near [3];
    logic signed [NW-1:0] a_far  [3];
    logic        [DW-1:0] a_d    [3];
    logic                 a_zero [3];
    logic                 a_rej  [3];
    logic                 r_vld_a;

    logic                 r_vld_b, r_rej_b;
    logic signed [NW-1:0] r_tmin_n_b, r_tmax_n_b;
    logic        [DW-1:0] r_tmin_d_b, r_tmax_d_b;
    logic signed [NW-1:0] r_near_y_b, r_far_y_b, r_near_z_b, r_far_z_b;
    logic        [DW-1:0] r_d_y_b, r_d_z_b;
    logic                 r_zero_y_b, r_zero_z_b;

    logic signed [NW-1:0] r_near_z_c, r_far_z_c, r_near_z_d, r_far_z_d;
    logic        [DW-1:0] r_d_z_c, r_d_z_d;
    logic                 r_zero_z_c, r_zero_z_d;

    logic                 y_vld, y_rej, z_vld, z_rej;
    logic signed [NW-1:0] y_tmin_n, y_tmax_n, z_tmin_n, z_tmax_n;
    logic        [DW-1:0] y_tmin_d, y_tmax_d, z_tmin_d, z_tmax_d;

    logic                 r_vld_g, r_rej_g;
    logic signed [PW-1:0] r_pa, r_pb;
    logic                 r_vld_h, r_hit;

    t_stage_ctl ctl_y, ctl_z;

    assign en         = !r_vld_h || o_out.ready;
    assign i_in.ready = en;
    assign ctl_y      = '{en: en, vld: r_vld_b};
    assign ctl_z      = '{en: en, vld: y_vld};

    sbi_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep_x (
        .i_clk(i_clk), .i_en(en), .i_start(i_in.start_x), .i_end(i_in.end_x),
        .i_lo(i_in.box_min_x), .i_hi(i_in.box_max_x),
        .o_near(a_near[0]), .o_far(a_far[0]), .o_d(a_d[0]),
        .o_zero(a_zero[0]), .o_rej(a_rej[0])
    );
    sbi_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep_y (
        .i_clk(i_clk), .i_en(en), .i_start(i_in.start_y), .i_end(i_in.end_y),
        .i_lo(i_in.box_min_y), .i_hi(i_in.box_max_y),
        .o_near(a_near[1]), .o_far(a_far[1]), .o_d(a_d[1]),
        .o_zero(a_zero[1]), .o_rej(a_rej[1])
    );
    sbi_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep_z (
        .i_clk(i_clk), .i_en(en), .i_start(i_in.start_z), .i_end(i_in.end_z),
        .i_lo(i_in.box_min_z), .i_hi(i_in.box_max_z),
        .o_near(a_near[2]), .o_far(a_far[2]), .o_d(a_d[2]),
        .o_zero(a_zero[2]), .o_rej(a_rej[2])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_g <= 1'b0;
            r_vld_h <= 1'b0;
        end else if (en) begin
            r_vld_a <= i_in.valid;
            r_vld_b <= r_vld_a;
            r_vld_g <= z_vld;
            r_vld_h <= r_vld_g;
        end
    end

    // seed the interval from x
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rej_b <= a_rej[0] || a_rej[1] || a_rej[2];
            if (!a_zero[0] && (a_near[0] > 0)) begin
                r_tmin_n_b <= a_near[0];
                r_tmin_d_b <= a_d[0];
            end else begin
                r_tmin_n_b <= '0;
                r_tmin_d_b <= DW'(1);
            end
            if (!a_zero[0] && (a_far[0] < $signed({1'b0, a_d[0]}))) begin
                r_tmax_n_b <= a_far[0];
                r_tmax_d_b <= a_d[0];
            end else begin
                r_tmax_n_b <= NW'(1);
                r_tmax_d_b <= DW'(1);
            end
            r_near_y_b <= a_near[1];
            r_far_y_b  <= a_far[1];
            r_d_y_b    <= a_d[1];
            r_zero_y_b <= a_zero[1];
            r_near_z_b <= a_near[2];
            r_far_z_b  <= a_far[2];
            r_d_z_b    <= a_d[2];
            r_zero_z_b <= a_zero[2];
            r_near_z_c <= r_near_z_b;
            r_far_z_c  <= r_far_z_b;
            r_d_z_c    <= r_d_z_b;
            r_zero_z_c <= r_zero_z_b;
            r_near_z_d <= r_near_z_c;
            r_far_z_d  <= r_far_z_c;
            r_d_z_d    <= r_d_z_c;
            r_zero_z_d <= r_zero_z_c;
        end
    end

    sbi_fold #(.COORD_WIDTH(COORD_WIDTH)) u_fold_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_y), .i_rej(r_rej_b),
        .i_tmin_n(r_tmin_n_b), .i_tmin_d(r_tmin_d_b),
        .i_tmax_n(r_tmax_n_b), .i_tmax_d(r_tmax_d_b),
        .i_near(r_near_y_b), .i_far(r_far_y_b), .i_d(r_d_y_b), .i_zero(r_zero_y_b),
        .o_vld(y_vld), .o_rej(y_rej),
        .o_tmin_n(y_tmin_n), .o_tmin_d(y_tmin_d),
        .o_tmax_n(y_tmax_n), .o_tmax_d(y_tmax_d)
    );

    sbi_fold #(.COORD_WIDTH(COORD_WIDTH)) u_fold_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl_z), .i_rej(y_rej),
        .i_tmin_n(y_tmin_n), .i_tmin_d(y_tmin_d),
        .i_tmax_n(y_tmax_n), .i_tmax_d(y_tmax_d),
        .i_near(r_near_z_d), .i_far(r_far_z_d), .i_d(r_d_z_d), .i_zero(r_zero_z_d),
        .o_vld(z_vld), .o_rej(z_rej),
        .o_tmin_n(z_tmin_n), .o_tmin_d(z_tmin_d),
        .o_tmax_n(z_tmax_n), .o_tmax_d(z_tmax_d)
    );

    // cross-multiply tmax against tmin, then decide
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rej_g <= z_rej;
            r_pa    <= PW'(z_tmax_n) * $signed({1'b0, z_tmin_d});
            r_pb    <= PW'(z_tmin_n) * $signed({1'b0, z_tmax_d});
            r_hit   <= !r_rej_g && !(r_pa < r_pb);
        end
    end

    assign o_out.valid = r_vld_h;
    assign o_out.hit   = r_hit;
endmodule

/* rtl/sbi_prep.sv */
`timescale 1ns / 1ps
module sbi_prep #(
    parameter int COORD_WIDTH = sbi_pkg::SBI_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_start,
    input  logic signed [COORD_WIDTH-1:0] i_end,
    input  logic signed [COORD_WIDTH-1:0] i_lo,
    input  logic signed [COORD_WIDTH-1:0] i_hi,
    output logic signed [COORD_WIDTH+1:0] o_near,
    output logic signed [COORD_WIDTH+1:0] o_far,
    output logic        [COORD_WIDTH:0]   o_d,
    output logic                          o_zero,
    output logic                          o_rej
);
    import sbi_pkg::*;

    localparam int NW = COORD_WIDTH + 2;
    localparam int DW = COORD_WIDTH + 1;

    logic signed [NW-1:0] d;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    logic signed [NW-1:0] n_near;
    logic signed [NW-1:0] n_far;
    logic signed [NW-1:0] d_abs;
    logic                 n_zero;
    logic                 n_rej;

    always_comb begin
        d  = NW'(i_end) - NW'(i_start);
        n1 = NW'(i_lo) - NW'(i_start);
        n2 = NW'(i_hi) - NW'(i_start);
        if (d < 0) begin
            n1    = -n1;
            n2    = -n2;
            d_abs = -d;
        end else begin
            d_abs = d;
        end
        n_near = (n1 < n2) ? n1 : n2;
        n_far  = (n1 < n2) ? n2 : n1;
        n_zero = (d == 0);
        n_rej  = n_zero && ((i_start < i_lo) || (i_start > i_hi));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_near <= n_near;
            o_far  <= n_far;
            o_d    <= d_abs[DW-1:0];
            o_zero <= n_zero;
            o_rej  <= n_rej;
        end
    end
endmodule

/* rtl/sbi_fold.sv */
`timescale 1ns / 1ps
module sbi_fold #(
    parameter int COORD_WIDTH = sbi_pkg::SBI_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sbi_pkg::t_stage_ctl           i_ctl,
    input  logic                          i_rej,
    input  logic signed [COORD_WIDTH+1:0] i_tmin_n,
    input  logic        [COORD_WIDTH:0]   i_tmin_d,
    input  logic signed [COORD_WIDTH+1:0] i_tmax_n,
    input  logic        [COORD_WIDTH:0]   i_tmax_d,
    input  logic signed [COORD_WIDTH+1:0] i_near,
    input  logic signed [COORD_WIDTH+1:0] i_far,
    input  logic        [COORD_WIDTH:0]   i_d,
    input  logic                          i_zero,
    output logic                          o_vld,
    output logic                          o_rej,
    output logic signed [COORD_WIDTH+1:0] o_tmin_n,
    output logic        [COORD_WIDTH:0]   o_tmin_d,
    output logic signed [COORD_WIDTH+1:0] o_tmax_n,
    output logic        [COORD_WIDTH:0]   o_tmax_d
);
    import sbi_pkg::*;

    localparam int NW = COORD_WIDTH + 2;
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = NW + DW + 1;

    logic                 r_vld;
    logic                 r_rej;
    logic                 r_zero;
    logic signed [NW-1:0] r_tmin_n, r_tmax_n, r_near, r_far;
    logic        [DW-1:0] r_tmin_d, r_tmax_d, r_d;
    logic signed [PW-1:0] r_p1, r_p2, r_p3, r_p4;

    // multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rej    <= i_rej;
            r_zero   <= i_zero;
            r_tmin_n <= i_tmin_n;
            r_tmin_d <= i_tmin_d;
            r_tmax_n <= i_tmax_n;
            r_tmax_d <= i_tmax_d;
            r_near   <= i_near;
            r_far    <= i_far;
            r_d      <= i_d;
            r_p1     <= PW'(i_tmin_n) * $signed({1'b0, i_d});
            r_p2     <= PW'(i_near) * $signed({1'b0, i_tmin_d});
            r_p3     <= PW'(i_far) * $signed({1'b0, i_tmax_d});
            r_p4     <= PW'(i_tmax_n) * $signed({1'b0, i_d});
        end
    end

    // narrow the interval
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_ctl.en) begin
            o_vld <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            o_rej <= r_rej;
            if (!r_zero && (r_p1 < r_p2)) begin
                o_tmin_n <= r_near;
                o_tmin_d <= r_d;
            end else begin
                o_tmin_n <= r_tmin_n;
                o_tmin_d <= r_tmin_d;
            end
            if (!r_zero && (r_p3 < r_p4)) begin
                o_tmax_n <= r_far;
                o_tmax_d <= r_d;
            end else begin
                o_tmax_n <= r_tmax_n;
                o_tmax_d <= r_tmax_d;
            end
        end
    end
endmodule

/* rtl/sbi_checker.sv */
`timescale 1ns / 1ps
module sbi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_hit
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit))
        else $error("result dropped or changed under stall");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("request ready does not follow result stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind segment_box_intersect sbi_checker u_sbi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hit   (o_out.hit)
);
